// ----- sv/irc_lfs_pkg.sv -----
// Shared types, constants and helpers for the IRC line field splitter.
`default_nettype none

package irc_lfs_pkg;

    localparam int LINE_MAX = 512;
    localparam int CNT_W    = $clog2(LINE_MAX + 1);

    localparam int KIND_W   = 3;
    localparam int OFS_W    = 10;
    localparam int ERR_W    = 2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [KIND_W-1:0] KIND_NICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_USER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HOST  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CMD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARAM = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FINAL = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_CR    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_NICK   = 3'd1,
        ST_USER   = 3'd2,
        ST_HOST   = 3'd3,
        ST_CMD    = 3'd4,
        ST_PARAMS = 3'd5,
        ST_TRAIL  = 3'd6,
        ST_END    = 3'd7
    } t_parse_state;

    typedef struct packed {
        logic              has;
        logic [KIND_W-1:0] kind;
        logic [OFS_W-1:0]  start;
        logic [OFS_W-1:0]  length;
        logic              line_end;
        logic [ERR_W-1:0]  error;
    } t_result;

    // Reduces a counter value to the width of the offset fields.
    function automatic logic [OFS_W-1:0] to_ofs(input logic [CNT_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[OFS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/irc_lfs_parser.sv -----
// Parse state, line counters and field result logic for one byte per step.
`default_nettype none

module irc_lfs_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    output irc_lfs_pkg::t_result      o_res
);

    localparam logic [irc_lfs_pkg::CNT_W-1:0] CNT_MAX =
        irc_lfs_pkg::CNT_W'(irc_lfs_pkg::LINE_MAX);

    irc_lfs_pkg::t_parse_state r_state, n_state;
    logic [irc_lfs_pkg::CNT_W-1:0] r_count, n_count;
    logic [irc_lfs_pkg::CNT_W-1:0] r_ofs, n_ofs;
    logic r_ovf, n_ovf;

    logic [irc_lfs_pkg::CNT_W-1:0] cnt_inc;
    logic [irc_lfs_pkg::CNT_W:0]   ofs_p1;
    logic [irc_lfs_pkg::CNT_W-1:0] close_len;
    logic [irc_lfs_pkg::CNT_W-1:0] final_len;
    logic                          is_cr, is_lf;
    logic                          do_close;
    logic [irc_lfs_pkg::KIND_W-1:0] close_kind;

    assign is_cr   = (i_byte == irc_lfs_pkg::CH_CR);
    assign is_lf   = (i_byte == irc_lfs_pkg::CH_LF);
    assign cnt_inc = (r_count < CNT_MAX) ? r_count + 1'b1 : r_count;
    assign ofs_p1  = {1'b0, r_ofs} + 1'b1;

    // The delimiter has already been counted, so the closed field is one short.
    assign close_len = ({1'b0, cnt_inc} >= ofs_p1) ? (cnt_inc - r_ofs - 1'b1) : '0;
    assign final_len = (r_count >= r_ofs) ? (r_count - r_ofs) : '0;

    always_comb begin
        do_close   = 1'b0;
        close_kind = irc_lfs_pkg::KIND_CMD;
        unique case (r_state)
            irc_lfs_pkg::ST_INIT: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_SPACE);
                close_kind = irc_lfs_pkg::KIND_CMD;
            end
            irc_lfs_pkg::ST_NICK: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_BANG);
                close_kind = irc_lfs_pkg::KIND_NICK;
            end
            irc_lfs_pkg::ST_USER: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_AT);
                close_kind = irc_lfs_pkg::KIND_USER;
            end
            irc_lfs_pkg::ST_HOST: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_SPACE);
                close_kind = irc_lfs_pkg::KIND_HOST;
            end
            irc_lfs_pkg::ST_CMD: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_SPACE);
                close_kind = irc_lfs_pkg::KIND_CMD;
            end
            irc_lfs_pkg::ST_PARAMS: begin
                do_close   = (i_byte == irc_lfs_pkg::CH_SPACE);
                close_kind = irc_lfs_pkg::KIND_PARAM;
            end
            irc_lfs_pkg::ST_TRAIL,
            irc_lfs_pkg::ST_END: begin
                do_close   = 1'b0;
                close_kind = irc_lfs_pkg::KIND_CMD;
            end
            default: begin
                do_close   = 1'b0;
                close_kind = irc_lfs_pkg::KIND_CMD;
            end
        endcase
    end

    // Next state and counters.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ofs   = r_ofs;
        n_ovf   = r_ovf;
        if (i_step) begin
            priority if (is_cr) begin
                n_state = irc_lfs_pkg::ST_END;
            end else if (is_lf) begin
                n_state = irc_lfs_pkg::ST_INIT;
                n_count = '0;
                n_ofs   = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = cnt_inc;
                if (r_count >= CNT_MAX) begin
                    n_ovf = 1'b1;
                end
                if (do_close) begin
                    n_ofs = cnt_inc;
                end
                unique case (r_state)
                    irc_lfs_pkg::ST_INIT: begin
                        if (i_byte == irc_lfs_pkg::CH_COLON) begin
                            n_ofs   = cnt_inc;
                            n_state = irc_lfs_pkg::ST_NICK;
                        end else if (do_close) begin
                            n_state = irc_lfs_pkg::ST_PARAMS;
                        end else begin
                            n_state = irc_lfs_pkg::ST_CMD;
                        end
                    end
                    irc_lfs_pkg::ST_NICK: begin
                        if (do_close) n_state = irc_lfs_pkg::ST_USER;
                    end
                    irc_lfs_pkg::ST_USER: begin
                        if (do_close) n_state = irc_lfs_pkg::ST_HOST;
                    end
                    irc_lfs_pkg::ST_HOST: begin
                        if (do_close) n_state = irc_lfs_pkg::ST_CMD;
                    end
                    irc_lfs_pkg::ST_CMD: begin
                        if (do_close) n_state = irc_lfs_pkg::ST_PARAMS;
                    end
                    irc_lfs_pkg::ST_PARAMS: begin
                        // A colon that opens a parameter starts the trailing one.
                        if (!do_close && i_byte == irc_lfs_pkg::CH_COLON &&
                            {1'b0, cnt_inc} == ofs_p1) begin
                            n_ofs   = cnt_inc;
                            n_state = irc_lfs_pkg::ST_TRAIL;
                        end
                    end
                    irc_lfs_pkg::ST_TRAIL,
                    irc_lfs_pkg::ST_END: begin
                        n_state = r_state;
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end
    end

    // Result word for the byte now presented.
    always_comb begin
        o_res          = '0;
        o_res.kind     = close_kind;
        o_res.start    = irc_lfs_pkg::to_ofs(r_ofs);
        o_res.length   = irc_lfs_pkg::to_ofs(close_len);
        o_res.line_end = 1'b0;
        o_res.error    = irc_lfs_pkg::ERR_NONE;
        priority if (is_cr) begin
            o_res.has = 1'b0;
        end else if (is_lf) begin
            o_res.has      = 1'b1;
            o_res.line_end = 1'b1;
            if (r_state == irc_lfs_pkg::ST_END) begin
                o_res.kind   = irc_lfs_pkg::KIND_FINAL;
                o_res.length = irc_lfs_pkg::to_ofs(final_len);
                o_res.error  = r_ovf ? irc_lfs_pkg::ERR_OVERFLOW : irc_lfs_pkg::ERR_NONE;
            end else begin
                o_res.kind   = irc_lfs_pkg::KIND_NICK;
                o_res.start  = '0;
                o_res.length = '0;
                o_res.error  = irc_lfs_pkg::ERR_NO_CR;
            end
        end else begin
            o_res.has = do_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irc_lfs_pkg::ST_INIT;
            r_count <= '0;
            r_ofs   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ofs   <= n_ofs;
            r_ovf   <= n_ovf;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_MAX) && (r_ofs <= r_count))
        else $error("line counters out of range");

    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_lf) |=> (r_state == irc_lfs_pkg::ST_INIT && r_count == '0
                               && !r_ovf))
        else $error("line not cleared after LF");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_MAX))
        else $error("overflow flag set on a line that is not full");

    a_error_at_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.has && o_res.error != irc_lfs_pkg::ERR_NONE) |-> o_res.line_end)
        else $error("error reported on a word that does not end the line");

endmodule

`default_nettype wire

// ----- sv/irc_lfs_out_reg.sv -----
// Result register that holds a field word until the consumer takes it.
`default_nettype none

module irc_lfs_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire irc_lfs_pkg::t_result i_res,
    output logic                      o_free,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output irc_lfs_pkg::t_result      o_res
);

    logic                 r_valid;
    irc_lfs_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_load)
        else $error("held result word overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded word not presented");

    a_load_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> i_res.has)
        else $error("empty result loaded");

endmodule

`default_nettype wire

// ----- sv/irc_line_field_splitter.sv -----
// Top level of the IRC line field splitter: input register, parser, result register.
`default_nettype none

// Takes an IRC line one byte per word and emits one word for each field as it
// closes (nick, user, host, command, middle parameters, final field at LF),
// giving its kind, start offset and length. A byte is taken into an input
// register, parsed by combinational compare and counter logic against the line
// state, and its field word, if any, goes into a result register. One byte per
// cycle is sustained while the result register is not stalled; a field word
// goes from the input register through the parser into the result register. A
// stalled result register holds back only bytes that produce a field word; the
// line state updates in the same cycle the byte leaves the input register.
module irc_line_field_splitter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [7:0]                         i_data_byte,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [irc_lfs_pkg::KIND_W-1:0]          o_field_kind,
    output logic [irc_lfs_pkg::OFS_W-1:0]           o_field_start,
    output logic [irc_lfs_pkg::OFS_W-1:0]           o_field_length,
    output logic                                    o_line_end,
    output logic [irc_lfs_pkg::ERR_W-1:0]           o_error_code
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 advance;
    logic                 out_free;
    irc_lfs_pkg::t_result parse_res;
    irc_lfs_pkg::t_result out_res;

    assign advance    = r_in_valid && (!parse_res.has || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    irc_lfs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (parse_res)
    );

    irc_lfs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && parse_res.has),
        .i_res   (parse_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_field_kind   = out_res.kind;
    assign o_field_start  = out_res.start;
    assign o_field_length = out_res.length;
    assign o_line_end     = out_res.line_end;
    assign o_error_code   = out_res.error;

    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> (parse_res.has && o_out_valid && !i_out_ready))
        else $error("input stalled without a full result register");

    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && parse_res.has) |=> o_out_valid)
        else $error("field word dropped");

endmodule

`default_nettype wire
